/* rtl/atsc_pkg.sv */
// ----------------------------------------------------------------------------
// Assembler token scanner package
// Shared types, character codes and classification helpers for the scanner.
// ----------------------------------------------------------------------------
package atsc_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0]  ChSpace  = 8'h20;
    localparam logic [7:0]  ChTab    = 8'h09;
    localparam logic [7:0]  ChCr     = 8'h0D;
    localparam logic [7:0]  ChLf     = 8'h0A;
    localparam logic [7:0]  ChComma  = 8'h2C;
    localparam logic [7:0]  ChColon  = 8'h3A;
    localparam logic [7:0]  ChLbr    = 8'h5B;
    localparam logic [7:0]  ChRbr    = 8'h5D;
    localparam logic [7:0]  ChSemi   = 8'h3B;
    localparam logic [7:0]  ChMinus  = 8'h2D;
    localparam logic [7:0]  ChPlus   = 8'h2B;
    localparam logic [7:0]  ChZero   = 8'h30;
    localparam logic [7:0]  ChSeven  = 8'h37;
    localparam logic [7:0]  ChNine   = 8'h39;
    localparam logic [7:0]  ChLowA   = 8'h61;
    localparam logic [7:0]  ChLowZ   = 8'h7A;
    localparam logic [7:0]  ChUpA    = 8'h41;
    localparam logic [7:0]  ChUpZ    = 8'h5A;
    localparam logic [7:0]  ChUnder  = 8'h5F;
    localparam logic [7:0]  ChLowB   = 8'h62;
    localparam logic [7:0]  ChLowO   = 8'h6F;
    localparam logic [7:0]  ChLowX   = 8'h78;
    localparam logic [7:0]  CaseGap  = 8'h20;
    localparam logic [7:0]  DigitTen = 8'd10;

    localparam logic [4:0]  Base2    = 5'd2;
    localparam logic [4:0]  Base8    = 5'd8;
    localparam logic [4:0]  Base10   = 5'd10;
    localparam logic [4:0]  Base16   = 5'd16;

    localparam logic [7:0]  LenMax   = 8'hFF;
    localparam logic [15:0] LineMax  = 16'hFFFF;
    localparam logic [15:0] LineInit = 16'd1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_SIGN,
        MODE_ZERO,
        MODE_DIGITS,
        MODE_IDENT
    } t_mode;

    typedef enum logic [2:0] {
        KIND_EOS,
        KIND_COMMA,
        KIND_COLON,
        KIND_LBRACKET,
        KIND_RBRACKET,
        KIND_NUMBER,
        KIND_IDENT,
        KIND_ERROR
    } t_kind;

    typedef enum logic [3:0] {
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_COMMA,
        CLS_COLON,
        CLS_LBRACKET,
        CLS_RBRACKET,
        CLS_SEMI,
        CLS_SIGN,
        CLS_ZERO,
        CLS_DEC,
        CLS_LETTER,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  len;
        logic [15:0] line;
    } t_tok;

    typedef struct packed {
        logic two;
        t_tok tok0;
        t_tok tok1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        if (c == ChSpace || c == ChTab || c == ChCr) begin
            cls = CLS_SPACE;
        end else if (c == ChLf) begin
            cls = CLS_NEWLINE;
        end else if (c == ChComma) begin
            cls = CLS_COMMA;
        end else if (c == ChColon) begin
            cls = CLS_COLON;
        end else if (c == ChLbr) begin
            cls = CLS_LBRACKET;
        end else if (c == ChRbr) begin
            cls = CLS_RBRACKET;
        end else if (c == ChSemi) begin
            cls = CLS_SEMI;
        end else if (c == ChMinus || c == ChPlus) begin
            cls = CLS_SIGN;
        end else if (c == ChZero) begin
            cls = CLS_ZERO;
        end else if (c > ChZero && c <= ChNine) begin
            cls = CLS_DEC;
        end else if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ)
                     || c == ChUnder) begin
            cls = CLS_LETTER;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic t_mode idle_mode(input t_cls cls);
        t_mode m;
        case (cls)
            CLS_SEMI:   m = MODE_COMMENT;
            CLS_SIGN:   m = MODE_SIGN;
            CLS_ZERO:   m = MODE_ZERO;
            CLS_DEC:    m = MODE_DIGITS;
            CLS_LETTER: m = MODE_IDENT;
            default:    m = MODE_IDLE;
        endcase
        return m;
    endfunction

    function automatic t_digit digit_of(input logic [7:0] c, input logic [4:0] base);
        t_digit     d;
        logic [7:0] uc;
        d.valid = 1'b0;
        d.value = 4'(c - ChZero);
        uc      = c;
        if (base <= Base10) begin
            d.valid = (c >= ChZero) && (c < ChZero + {3'b000, base});
        end else if (c >= ChZero && c <= ChNine) begin
            d.valid = 1'b1;
        end else begin
            if (c >= ChLowA && c <= ChLowZ) begin
                uc = c - CaseGap;
            end
            if (uc >= ChUpA && uc < ChUpA + {3'b000, base} - DigitTen) begin
                d.valid = 1'b1;
                d.value = 4'(uc - ChUpA + DigitTen);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/assembler_token_scanner.sv */
// ----------------------------------------------------------------------------
// Assembler token scanner
// Streaming assembler source lexer; one character word per cycle while ready.
// ----------------------------------------------------------------------------
// The slave channel takes one source character per word, or an end-of-source
// mark in tuser; the master channel gives one token per word, with tlast set
// on the final token that an input word produced (one input makes at most two).
// The front end updates the lexer state on each accepted word, so a new
// character can be accepted every cycle while the queue is not full. Tokens
// pass through the queue and then the output register, which moves one token
// per cycle while the receiver is ready; the two tokens of one word leave in
// turn, and a queue of QUEUE_DEPTH entries absorbs these bursts.
// When the receiver stalls, the output register holds, the queue fills and
// then o_s_tready falls until space frees up. Reset empties the queue and the
// output register and returns the lexer to idle with the line count at one;
// an end-of-source word does the same to the lexer state after its tokens.
// ----------------------------------------------------------------------------
module assembler_token_scanner #(
    parameter int QUEUE_DEPTH = atsc_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic [0:0]  i_s_tuser,   // [0] eos_flag
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] number_value, [15:8] text_length,
                                     // [31:16] line_number
    output logic [2:0]  o_m_tuser,   // [2:0] token_kind
    output logic        o_m_tlast
);
    import atsc_pkg::*;

    t_qstat qstat;
    t_entry push_entry;
    t_entry head;
    logic   push;
    logic   pop;
    t_tok   tok;

    atsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_eos   (i_s_tuser[0]),
        .i_qstat (qstat),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    atsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    atsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .i_ready (i_m_tready),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_tok   (tok),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {tok.line, tok.len, tok.value};
    assign o_m_tuser = tok.kind;

endmodule

/* rtl/atsc_front.sv */
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts one character word per cycle while the queue has space, tracks the
// lexer state and queues the zero, one or two tokens that each word completes.
// ----------------------------------------------------------------------------
module atsc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char,
    input  logic              i_eos,
    input  atsc_pkg::t_qstat  i_qstat,
    output logic              o_ready,
    output logic              o_push,
    output atsc_pkg::t_entry  o_entry
);
    import atsc_pkg::*;

    t_mode       r_mode,  n_mode;
    logic [4:0]  r_base,  n_base;
    logic        r_minus, n_minus;
    logic [7:0]  r_acc,   n_acc;
    logic [7:0]  r_len,   n_len;
    logic [15:0] r_line,  n_line;

    logic        accept;
    t_cls        cls;
    logic [4:0]  base_zero;
    logic [4:0]  eff_base;
    t_digit      dig;
    logic        is_prefix;
    logic [4:0]  prefix_base;
    logic [12:0] prod;
    logic [7:0]  acc_mac;
    logic [7:0]  num_value;
    logic [7:0]  len_grow;
    logic [15:0] line_grow;
    logic        run_idle;
    logic        pre_valid;
    logic        post_valid;
    t_tok        pre_tok;
    t_tok        post_tok;

    assign accept    = i_valid && !i_qstat.full;
    assign o_ready   = !i_qstat.full;
    assign cls       = char_class(i_char);
    assign base_zero = (cls == CLS_ZERO || (cls == CLS_DEC && i_char <= ChSeven))
                       ? Base8 : Base10;
    assign eff_base  = (r_mode == MODE_ZERO) ? base_zero : r_base;
    assign dig       = digit_of(i_char, eff_base);
    assign is_prefix = (i_char == ChLowB) || (i_char == ChLowO) || (i_char == ChLowX);
    assign prefix_base = (i_char == ChLowB) ? Base2 : (i_char == ChLowO) ? Base8 : Base16;
    assign prod      = {5'b00000, r_acc} * {8'h00, eff_base};
    assign acc_mac   = prod[7:0] + {4'h0, dig.value};
    assign num_value = r_minus ? 8'(8'd0 - r_acc) : r_acc;
    assign len_grow  = (r_len == LenMax) ? r_len : r_len + 8'd1;
    assign line_grow = (r_line == LineMax) ? r_line : r_line + 16'd1;

    always_comb begin
        n_mode = r_mode;
        if (i_eos) begin
            n_mode = MODE_IDLE;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    n_mode = idle_mode(cls);
                end
                MODE_COMMENT: begin
                    if (cls == CLS_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SIGN: begin
                    if (cls == CLS_ZERO) begin
                        n_mode = MODE_ZERO;
                    end else if (cls == CLS_DEC) begin
                        n_mode = MODE_DIGITS;
                    end else begin
                        n_mode = idle_mode(cls);
                    end
                end
                MODE_ZERO, MODE_DIGITS: begin
                    if ((r_mode == MODE_ZERO && is_prefix) || dig.valid) begin
                        n_mode = MODE_DIGITS;
                    end else begin
                        n_mode = idle_mode(cls);
                    end
                end
                MODE_IDENT: begin
                    if (cls == CLS_LETTER || cls == CLS_ZERO || cls == CLS_DEC) begin
                        n_mode = MODE_IDENT;
                    end else begin
                        n_mode = idle_mode(cls);
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_base     = r_base;
        n_minus    = r_minus;
        n_acc      = r_acc;
        n_len      = r_len;
        n_line     = r_line;
        run_idle   = 1'b0;
        pre_valid  = 1'b0;
        post_valid = 1'b0;
        pre_tok    = '{kind: KIND_NUMBER, value: num_value, len: r_len, line: r_line};
        post_tok   = '{kind: KIND_EOS, value: 8'd0, len: 8'd0, line: r_line};

        if (i_eos) begin
            if (r_mode == MODE_ZERO || r_mode == MODE_DIGITS) begin
                pre_valid = 1'b1;
            end else if (r_mode == MODE_IDENT) begin
                pre_valid     = 1'b1;
                pre_tok.kind  = KIND_IDENT;
                pre_tok.value = 8'd0;
            end
            post_valid = 1'b1;
            n_base     = Base10;
            n_minus    = 1'b0;
            n_acc      = 8'd0;
            n_len      = 8'd0;
            n_line     = LineInit;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    run_idle = 1'b1;
                end
                MODE_COMMENT: begin
                    if (cls == CLS_NEWLINE) begin
                        n_line = line_grow;
                    end
                end
                MODE_SIGN: begin
                    if (cls == CLS_ZERO) begin
                        n_len = len_grow;
                    end else if (cls == CLS_DEC) begin
                        n_len  = len_grow;
                        n_acc  = i_char - ChZero;
                        n_base = Base10;
                    end else begin
                        pre_valid = 1'b1;
                        run_idle  = 1'b1;
                    end
                end
                MODE_ZERO, MODE_DIGITS: begin
                    if (r_mode == MODE_ZERO && is_prefix) begin
                        n_base = prefix_base;
                        n_len  = len_grow;
                    end else begin
                        n_base = eff_base;
                        if (dig.valid) begin
                            n_acc = acc_mac;
                            n_len = len_grow;
                        end else begin
                            pre_valid = 1'b1;
                            run_idle  = 1'b1;
                        end
                    end
                end
                MODE_IDENT: begin
                    if (cls == CLS_LETTER || cls == CLS_ZERO || cls == CLS_DEC) begin
                        n_len = len_grow;
                    end else begin
                        pre_valid     = 1'b1;
                        pre_tok.kind  = KIND_IDENT;
                        pre_tok.value = 8'd0;
                        run_idle      = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle) begin
                post_tok.len = 8'd1;
                case (cls)
                    CLS_NEWLINE: begin
                        n_line = line_grow;
                    end
                    CLS_COMMA: begin
                        post_valid    = 1'b1;
                        post_tok.kind = KIND_COMMA;
                    end
                    CLS_COLON: begin
                        post_valid    = 1'b1;
                        post_tok.kind = KIND_COLON;
                    end
                    CLS_LBRACKET: begin
                        post_valid    = 1'b1;
                        post_tok.kind = KIND_LBRACKET;
                    end
                    CLS_RBRACKET: begin
                        post_valid    = 1'b1;
                        post_tok.kind = KIND_RBRACKET;
                    end
                    CLS_SIGN: begin
                        n_minus = (i_char == ChMinus);
                        n_base  = Base10;
                        n_acc   = 8'd0;
                        n_len   = 8'd1;
                    end
                    CLS_ZERO: begin
                        n_minus = 1'b0;
                        n_base  = Base10;
                        n_acc   = 8'd0;
                        n_len   = 8'd1;
                    end
                    CLS_DEC: begin
                        n_minus = 1'b0;
                        n_base  = Base10;
                        n_acc   = i_char - ChZero;
                        n_len   = 8'd1;
                    end
                    CLS_LETTER: begin
                        n_len = 8'd1;
                    end
                    CLS_OTHER: begin
                        post_valid    = 1'b1;
                        post_tok.kind = KIND_ERROR;
                    end
                    default: begin
                        post_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_push       = accept && (pre_valid || post_valid);
    assign o_entry.two  = pre_valid && post_valid;
    assign o_entry.tok0 = pre_valid ? pre_tok : post_tok;
    assign o_entry.tok1 = post_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_base  <= Base10;
            r_minus <= 1'b0;
            r_acc   <= 8'd0;
            r_len   <= 8'd0;
            r_line  <= LineInit;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_base  <= n_base;
            r_minus <= n_minus;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_line  <= n_line;
        end
    end

endmodule

/* rtl/atsc_queue.sv */
// ----------------------------------------------------------------------------
// Token queue
// Small first-in first-out buffer of token entries between front and back.
// ----------------------------------------------------------------------------
module atsc_queue #(
    parameter int DEPTH = atsc_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atsc_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output atsc_pkg::t_entry  o_head,
    output atsc_pkg::t_qstat  o_qstat
);
    import atsc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_store [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_store[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wptr] <= i_entry;
        end
    end

endmodule

/* rtl/atsc_back.sv */
// ----------------------------------------------------------------------------
// Token emitter
// Unpacks queued entries into single token words on the output register.
// ----------------------------------------------------------------------------
module atsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atsc_pkg::t_entry  i_head,
    input  atsc_pkg::t_qstat  i_qstat,
    input  logic              i_ready,
    output logic              o_pop,
    output logic              o_valid,
    output atsc_pkg::t_tok    o_tok,
    output logic              o_last
);
    import atsc_pkg::*;

    logic r_valid;
    logic r_pend;
    logic r_last;
    t_tok r_tok;
    t_tok r_hold;
    logic load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !r_pend && !i_qstat.empty;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_head.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_tok  <= r_hold;
                r_last <= 1'b1;
            end else begin
                r_tok  <= i_head.tok0;
                r_last <= !i_head.two;
                r_hold <= i_head.tok1;
            end
        end
    end

endmodule

/* bench/tb_assembler_token_scanner.sv */
// ----------------------------------------------------------------------------
// Assembler token scanner testbench
// Streams source characters into the scanner and checks every token word it
// returns against a cycle-free lexer model. A short scripted sequence covers
// punctuation, unknown codes, signs, radix prefixes and end of source. A long
// random mix of numbers, identifiers, comments and noise follows, then very
// long tokens that push the length count to its ceiling.
// ----------------------------------------------------------------------------
module tb_assembler_token_scanner;

    import atsc_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  len;
        logic [15:0] line;
        logic        last;
    } t_lex_token;

    typedef struct packed {
        logic        eos;
        logic [7:0]  ch;
        logic        typed;
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  len;
        logic [15:0] line;
    } t_script_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] char_code
    logic [0:0]  i_s_tuser  = 1'b0;    // [0] eos_flag
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;            // [7:0] number_value, [15:8] text_length,
                                       // [31:16] line_number
    logic [2:0]  o_m_tuser;            // [2:0] token_kind
    logic        o_m_tlast;

    t_mode       lx_mode;
    logic [4:0]  lx_base;
    logic        lx_neg;
    logic [7:0]  lx_acc;
    logic [7:0]  lx_len;
    logic [15:0] lx_line;

    t_lex_token  fresh_toks[$];
    t_lex_token  pending_tokens[$];
    int          errors     = 0;
    int          words_sent = 0;
    logic        no_gaps    = 1'b0;

    logic [7:0]  seps [8] = '{ChSpace, ChTab, ChCr, ChLf, ChComma, ChColon, ChLbr, ChRbr};
    logic [7:0]  prefix_letters [3] = '{ChLowB, ChLowO, ChLowX};

    t_script_row script_rows [26] = '{
        '{1'b1, 8'h00,   1'b1, KIND_EOS,      8'd0, 8'd0, 16'd1},
        '{1'b0, ChComma, 1'b1, KIND_COMMA,    8'd0, 8'd1, 16'd1},
        '{1'b0, ChColon, 1'b1, KIND_COLON,    8'd0, 8'd1, 16'd1},
        '{1'b0, ChLbr,   1'b1, KIND_LBRACKET, 8'd0, 8'd1, 16'd1},
        '{1'b0, ChRbr,   1'b1, KIND_RBRACKET, 8'd0, 8'd1, 16'd1},
        '{1'b0, 8'h00,   1'b1, KIND_ERROR,    8'd0, 8'd1, 16'd1},
        '{1'b0, 8'hFF,   1'b1, KIND_ERROR,    8'd0, 8'd1, 16'd1},
        '{1'b0, ChLf,    1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChMinus, 1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChSemi,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, 8'h80,   1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChLf,    1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChMinus, 1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChZero,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChLowX,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, "F",     1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, "f",     1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChTab,   1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChZero,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, "9",     1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChCr,    1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChZero,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, "X",     1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChUnder, 1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b0, ChPlus,  1'b0, KIND_EOS,      8'd0, 8'd0, 16'd0},
        '{1'b1, 8'h5A,   1'b1, KIND_EOS,      8'd0, 8'd0, 16'd3}
    };

    assembler_token_scanner u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void lex_reset();
        lx_mode = MODE_IDLE;
        lx_base = Base10;
        lx_neg  = 1'b0;
        lx_acc  = 8'd0;
        lx_len  = 8'd0;
        lx_line = LineInit;
    endfunction

    function automatic void put_tok(input t_kind k, input logic [7:0] v, input logic [7:0] n);
        t_lex_token t;
        t.kind  = k;
        t.value = v;
        t.len   = n;
        t.line  = lx_line;
        t.last  = 1'b0;
        fresh_toks.push_back(t);
    endfunction

    function automatic void put_number();
        put_tok(KIND_NUMBER, lx_neg ? 8'(8'd0 - lx_acc) : lx_acc, lx_len);
    endfunction

    function automatic void grow_len();
        if (lx_len != LenMax) begin
            lx_len = lx_len + 8'd1;
        end
    endfunction

    function automatic void bump_line();
        if (lx_line != LineMax) begin
            lx_line = lx_line + 16'd1;
        end
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) || c == ChUnder;
    endfunction

    // Value of c as a digit of the given base, or -1 when it is not one.
    function automatic int radix_digit(input logic [7:0] c, input logic [4:0] base);
        int ci;
        int b;
        ci = c;
        b  = base;
        if (b <= 10) begin
            return (ci >= ChZero && ci < ChZero + b) ? ci - ChZero : -1;
        end
        if (is_dec(c)) begin
            return ci - ChZero;
        end
        if (ci >= ChLowA && ci <= ChLowZ) begin
            ci = ci - CaseGap;
        end
        if (ci >= ChUpA && ci < ChUpA + b - 10) begin
            return ci - ChUpA + 10;
        end
        return -1;
    endfunction

    function automatic void start_number(input logic neg);
        lx_neg  = neg;
        lx_base = Base10;
        lx_acc  = 8'd0;
        lx_len  = 8'd1;
    endfunction

    function automatic void scan_idle(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        case (c)
            ChSpace, ChTab, ChCr: begin
            end
            ChLf:    bump_line();
            ChComma: put_tok(KIND_COMMA, 8'd0, 8'd1);
            ChColon: put_tok(KIND_COLON, 8'd0, 8'd1);
            ChLbr:   put_tok(KIND_LBRACKET, 8'd0, 8'd1);
            ChRbr:   put_tok(KIND_RBRACKET, 8'd0, 8'd1);
            ChSemi:  lx_mode = MODE_COMMENT;
            ChMinus, ChPlus: begin
                start_number(c == ChMinus);
                lx_mode = MODE_SIGN;
            end
            ChZero: begin
                start_number(1'b0);
                lx_mode = MODE_ZERO;
            end
            default: begin
                if (is_dec(c)) begin
                    start_number(1'b0);
                    lx_acc  = c - ChZero;
                    lx_mode = MODE_DIGITS;
                end else if (is_alpha(c)) begin
                    lx_len  = 8'd1;
                    lx_mode = MODE_IDENT;
                end else begin
                    put_tok(KIND_ERROR, 8'd0, 8'd1);
                end
            end
        endcase
    endfunction

    function automatic void scan_digit(input logic [7:0] c);
        int d;
        d = radix_digit(c, lx_base);
        if (d >= 0) begin
            lx_acc = 8'(lx_acc * lx_base + d);
            grow_len();
        end else begin
            put_number();
            scan_idle(c);
        end
    endfunction

    // Advances the lexer by one input word and leaves its tokens in fresh_toks.
    function automatic void lex_word(input logic eos, input logic [7:0] c);
        t_lex_token t;
        fresh_toks.delete();
        if (eos) begin
            if (lx_mode == MODE_ZERO || lx_mode == MODE_DIGITS) begin
                put_number();
            end else if (lx_mode == MODE_IDENT) begin
                put_tok(KIND_IDENT, 8'd0, lx_len);
            end
            put_tok(KIND_EOS, 8'd0, 8'd0);
            lex_reset();
        end else begin
            case (lx_mode)
                MODE_COMMENT: begin
                    if (c == ChLf) begin
                        bump_line();
                        lx_mode = MODE_IDLE;
                    end
                end
                MODE_SIGN: begin
                    if (c == ChZero) begin
                        grow_len();
                        lx_mode = MODE_ZERO;
                    end else if (is_dec(c)) begin
                        grow_len();
                        lx_acc  = c - ChZero;
                        lx_base = Base10;
                        lx_mode = MODE_DIGITS;
                    end else begin
                        put_number();
                        scan_idle(c);
                    end
                end
                MODE_ZERO: begin
                    lx_mode = MODE_DIGITS;
                    if (c == ChLowB || c == ChLowO || c == ChLowX) begin
                        lx_base = (c == ChLowB) ? Base2 : (c == ChLowO) ? Base8 : Base16;
                        grow_len();
                    end else begin
                        lx_base = (c >= ChZero && c <= ChSeven) ? Base8 : Base10;
                        scan_digit(c);
                    end
                end
                MODE_DIGITS: scan_digit(c);
                MODE_IDENT: begin
                    if (is_alpha(c) || is_dec(c)) begin
                        grow_len();
                    end else begin
                        put_tok(KIND_IDENT, 8'd0, lx_len);
                        scan_idle(c);
                    end
                end
                default: scan_idle(c);
            endcase
        end
        if (fresh_toks.size() > 0) begin
            t      = fresh_toks.pop_back();
            t.last = 1'b1;
            fresh_toks.push_back(t);
        end
    endfunction

    function automatic logic [7:0] pick_digit(input int base);
        int d;
        d = $urandom_range(0, base - 1);
        if (d < 10) begin
            return 8'(ChZero + d);
        end
        return 8'(($urandom_range(0, 1) ? ChLowA : ChUpA) + d - 10);
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return 8'(ChLowA + r);
        end
        if (r < 52) begin
            return 8'(ChUpA + r - 26);
        end
        return ChUnder;
    endfunction

    // Drives one word and returns at the clock edge that accepts it. A typed
    // row queues its written expectation in place of the model's tokens.
    task automatic send_word(input logic eos, input logic [7:0] ch, input logic typed,
                             input t_lex_token want);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 13) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= eos;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        lex_word(eos, ch);
        if (typed) begin
            pending_tokens.push_back(want);
        end else begin
            foreach (fresh_toks[k]) begin
                pending_tokens.push_back(fresh_toks[k]);
            end
        end
        words_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_word(1'b0, c, 1'b0, '0);
    endtask

    task automatic send_random_token();
        int         r;
        int         n;
        int         base;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_char(ChMinus);
            end else if (r < 40) begin
                send_char(ChPlus);
            end
            n = $urandom_range(0, 4);
            case ($urandom_range(0, 5))
                0: begin
                    base = 10;
                    if (n > 0) begin
                        send_char(8'($urandom_range(ChZero + 1, ChNine)));
                        n--;
                    end
                end
                1: begin
                    send_char(ChZero);
                    send_char(ChLowB);
                    base = 2;
                end
                2: begin
                    send_char(ChZero);
                    send_char(ChLowO);
                    base = 8;
                end
                3: begin
                    send_char(ChZero);
                    send_char(ChLowX);
                    base = 16;
                end
                4: begin
                    send_char(ChZero);
                    base = ($urandom_range(0, 3) == 0) ? 10 : 8;
                end
                default: begin
                    send_char(ChZero);
                    send_char(8'(prefix_letters[$urandom_range(0, 2)] - CaseGap));
                    base = 16;
                end
            endcase
            repeat (n) send_char(pick_digit(base));
        end else if (r < 65) begin
            send_char(pick_letter());
            repeat ($urandom_range(0, 6)) begin
                send_char(($urandom_range(0, 2) == 0) ? pick_digit(10) : pick_letter());
            end
        end else if (r < 78) begin
            send_char(seps[$urandom_range(4, 7)]);
        end else if (r < 85) begin
            send_char(ChSemi);
            repeat ($urandom_range(0, 5)) begin
                c = 8'($urandom_range(0, 255));
                if (c == ChLf) begin
                    c = ChSpace;
                end
                send_char(c);
            end
            send_char(ChLf);
        end else if (r < 93) begin
            send_char(8'($urandom_range(0, 255)));
        end else if (r < 96) begin
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 3)) send_char(seps[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 99) < 60) begin
            send_char(seps[$urandom_range(0, 7)]);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge i_clk) begin : token_check
        t_lex_token want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: token word with none expected, got kind %0d data %h last %b",
                         $time, o_m_tuser, o_m_tdata, o_m_tlast);
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", want.kind, o_m_tuser);
                check_field("number_value", want.value, o_m_tdata[7:0]);
                check_field("text_length", want.len, o_m_tdata[15:8]);
                check_field("line_number", want.line, o_m_tdata[31:16]);
                check_field("last_of_run", want.last, o_m_tlast);
            end
        end
    end

    initial begin
        t_lex_token want;
        lex_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r]) begin
            want.kind  = script_rows[r].kind;
            want.value = script_rows[r].value;
            want.len   = script_rows[r].len;
            want.line  = script_rows[r].line;
            want.last  = 1'b1;
            send_word(script_rows[r].eos, script_rows[r].ch, script_rows[r].typed, want);
        end

        words_sent = 0;
        while (words_sent < 520) begin
            no_gaps = (words_sent >= 200 && words_sent < 350);
            send_random_token();
        end
        no_gaps = 1'b0;

        // Tokens long enough to saturate the length count.
        send_char(ChLowZ);
        repeat (259) send_char(pick_letter());
        send_char(ChSpace);
        send_char(ChMinus);
        send_char(ChZero);
        send_char(ChLowX);
        repeat (257) send_char(pick_digit(16));
        send_char(ChComma);

        send_char(8'h7F);
        send_char(ChComma);
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        for (int w = 0; w < 2000 && pending_tokens.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            errors++;
            $display("%0t: expected %0d more token words, got none", $time,
                     pending_tokens.size());
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
